// ===== rtl/esc_pkg.sv =====
// Shared types, constants and a helper function for the epoch-seconds to
// calendar converter. No dependencies; every other file imports this package.
package esc_pkg;

  // Field widths of the input and result words.
  localparam int EPOCH_W  = 32;
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int MDAY_W   = 5;
  localparam int MON_W    = 4;
  localparam int YEAR_W   = 8;

  // Day count since the epoch fits 16 bits for any 32-bit input.
  localparam int DAYS_W   = 16;

  // Shared constant divider: a reciprocal multiply, then a remainder step.
  // q = (x * RECIP) >> SHIFT is exact for every 32-bit x with these pairs.
  localparam int DIV_STEPS         = 2;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);
  localparam int REM_W             = 6;
  localparam int PROD_W            = 2 * EPOCH_W;

  localparam logic [EPOCH_W-1:0] RECIP_BY_60 = 32'h8888_8889;
  localparam int                 SHIFT_BY_60 = 37;
  localparam logic [EPOCH_W-1:0] RECIP_BY_24 = 32'hAAAA_AAAB;
  localparam int                 SHIFT_BY_24 = 36;

  // Divider pass codes.
  localparam logic [1:0] DIV_SEC  = 2'd0;
  localparam logic [1:0] DIV_MIN  = 2'd1;
  localparam logic [1:0] DIV_HOUR = 2'd2;

  // Calendar constants.
  localparam logic [YEAR_W-1:0] EPOCH_YEAR_SINCE_1900 = YEAR_W'(1970 - 1900);
  localparam logic [6:0]        EPOCH_YEAR_MOD100     = 7'(1970 % 100);
  localparam logic [8:0]        EPOCH_YEAR_MOD400     = 9'(1970 % 400);
  localparam logic [6:0]        MOD100_LAST           = 7'(100 - 1);
  localparam logic [8:0]        MOD400_LAST           = 9'(400 - 1);
  localparam logic [8:0]        DAYS_COMMON_YEAR      = 9'(365);
  localparam logic [8:0]        DAYS_LEAP_YEAR        = 9'(366);
  localparam logic [MON_W-1:0]  LAST_MONTH            = MON_W'(11);

  // Length of a month, 0 = January, in a common or a leap year.
  function automatic logic [MDAY_W-1:0] month_days(input logic leap,
                                                   input logic [MON_W-1:0] mon);
    logic [MDAY_W-1:0] len;
    case (mon)
      MON_W'(1):                         len = leap ? MDAY_W'(29) : MDAY_W'(28);
      MON_W'(3), MON_W'(5), MON_W'(8),
      MON_W'(10):                        len = MDAY_W'(30);
      default:                           len = MDAY_W'(31);
    endcase
    return len;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       div_last;
    logic [1:0] div_sel;
    logic       year_step;
    logic       month_step;
    logic       out_load;
  } esc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_more;
    logic month_more;
  } esc_sts_t;

endpackage

// ===== rtl/esc_if.sv =====
// Valid/ready channel interfaces for the input and result words.
// Depends on esc_pkg for the field widths.
interface esc_in_if import esc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if import esc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SEC_W-1:0]  second;
  logic [MIN_W-1:0]  minute;
  logic [HOUR_W-1:0] hour;
  logic [MDAY_W-1:0] day_of_month;
  logic [MON_W-1:0]  month_index;
  logic [YEAR_W-1:0] year_since_1900;

  modport source (output valid, output second, output minute, output hour,
                  output day_of_month, output month_index, output year_since_1900,
                  input ready);
  modport sink   (input valid, input second, input minute, input hour,
                  input day_of_month, input month_index, input year_since_1900,
                  output ready);
endinterface

// ===== rtl/esc_dp.sv =====
// Datapath of the converter: shared reciprocal divider, year and month
// reduction, result register. Depends on esc_pkg.
module esc_dp import esc_pkg::*; (
  input  logic               clk,
  input  esc_cmd_t           cmd,
  input  logic [EPOCH_W-1:0] epoch_seconds,
  output esc_sts_t           sts,
  output logic [SEC_W-1:0]   second,
  output logic [MIN_W-1:0]   minute,
  output logic [HOUR_W-1:0]  hour,
  output logic [MDAY_W-1:0]  day_of_month,
  output logic [MON_W-1:0]   month_index,
  output logic [YEAR_W-1:0]  year_since_1900
);

  logic [EPOCH_W-1:0] num_r;
  logic [EPOCH_W-1:0] quo_r, quo_nxt;
  logic [SEC_W-1:0]   sec_r;
  logic [MIN_W-1:0]   min_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [DAYS_W-1:0]  days_r;
  logic [YEAR_W-1:0]  year_r;
  logic [6:0]         mod100_r;
  logic [8:0]         mod400_r;
  logic [MON_W-1:0]   mon_r;

  logic [EPOCH_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [EPOCH_W-1:0] back;
  logic [EPOCH_W-1:0] rem_all;
  logic [REM_W-1:0]   rem_nxt;
  logic               leap;
  logic [8:0]         year_len;
  logic [MDAY_W-1:0]  mon_len;

  // First step of a pass: quotient by reciprocal multiply. Second step:
  // remainder = dividend - quotient * divisor, the product by shifts
  // (24q = 16q + 8q, 60q = 64q - 4q).
  always_comb begin
    recip   = (cmd.div_sel == DIV_HOUR) ? RECIP_BY_24 : RECIP_BY_60;
    prod    = {{EPOCH_W{1'b0}}, num_r} * {{EPOCH_W{1'b0}}, recip};
    quo_nxt = (cmd.div_sel == DIV_HOUR) ? EPOCH_W'(prod[PROD_W-1:SHIFT_BY_24]) :
                                          EPOCH_W'(prod[PROD_W-1:SHIFT_BY_60]);
    back    = (cmd.div_sel == DIV_HOUR) ? (quo_r << 4) + (quo_r << 3) :
                                          (quo_r << 6) - (quo_r << 2);
    rem_all = num_r - back;
    rem_nxt = rem_all[REM_W-1:0];
  end

  // Gregorian leap rule from the year counters; 1900 is a multiple of four.
  assign leap     = ((year_r[1:0] == 2'b00) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);
  assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
  assign mon_len  = month_days(leap, mon_r);

  assign sts.year_more  = (days_r >= DAYS_W'(year_len));
  assign sts.month_more = (mon_r != LAST_MONTH) && (days_r >= DAYS_W'(mon_len));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r    <= epoch_seconds;
      year_r   <= EPOCH_YEAR_SINCE_1900;
      mod100_r <= EPOCH_YEAR_MOD100;
      mod400_r <= EPOCH_YEAR_MOD400;
      mon_r    <= '0;
    end else if (cmd.div_step) begin
      if (cmd.div_last) begin
        num_r <= quo_r;
        case (cmd.div_sel)
          DIV_SEC:  sec_r  <= SEC_W'(rem_nxt);
          DIV_MIN:  min_r  <= MIN_W'(rem_nxt);
          default: begin
            hour_r <= HOUR_W'(rem_nxt);
            days_r <= quo_r[DAYS_W-1:0];
          end
        endcase
      end else begin
        quo_r <= quo_nxt;
      end
    end else if (cmd.year_step) begin
      days_r   <= days_r - DAYS_W'(year_len);
      year_r   <= year_r + YEAR_W'(1);
      mod100_r <= (mod100_r == MOD100_LAST) ? 7'd0 : mod100_r + 7'd1;
      mod400_r <= (mod400_r == MOD400_LAST) ? 9'd0 : mod400_r + 9'd1;
    end else if (cmd.month_step) begin
      days_r <= days_r - DAYS_W'(mon_len);
      mon_r  <= mon_r + MON_W'(1);
    end
  end

  // Result register; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      second          <= sec_r;
      minute          <= min_r;
      hour            <= hour_r;
      day_of_month    <= days_r[MDAY_W-1:0] + MDAY_W'(1);
      month_index     <= mon_r;
      year_since_1900 <= year_r;
    end
  end

endmodule

// ===== rtl/esc_ctrl.sv =====
// Sequencing controller of the converter: divider passes, year and month
// loops, result handoff. Depends on esc_pkg.
module esc_ctrl import esc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  esc_sts_t sts,
  output esc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_YEAR  = 3'd2;
  localparam logic [2:0] S_MONTH = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]           sel_r, sel_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.div_sel = sel_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          sel_nxt   = DIV_SEC;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          cmd.div_last = 1'b1;
          cnt_nxt      = '0;
          if (sel_r == DIV_HOUR) begin
            state_nxt = S_YEAR;
          end else begin
            sel_nxt = sel_r + 2'd1;
          end
        end
      end
      S_YEAR: begin
        if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (sts.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= DIV_SEC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/epoch_seconds_to_calendar.sv =====
// Top level of the epoch-seconds to Gregorian calendar converter.
// Depends on esc_pkg, esc_if (channels), esc_ctrl and esc_dp.
//
// Usage:
//   One word on in_ch carries a 32-bit unsigned count of seconds since
//   1970-01-01 00:00:00. One word on out_ch returns second, minute, hour,
//   day_of_month (from 1), month_index (0 is January) and year_since_1900.
//   A word moves on either channel at a rising clock edge with valid and
//   ready both high.
// Sequence:
//   A conversion captures the input, runs the shared divider (a reciprocal
//   multiply and a remainder step for each of the divisions by 60, 60 and
//   24), runs the year loop, which takes off one whole year past 1970 per
//   step until the days left fall short of a year, runs the month loop in
//   the same way with whole months, and hands off the result. One word is
//   converted at a time, so a new word is taken only after the previous
//   result has been loaded into the output register.
// Reset and stalls:
//   rst_n is synchronous and active low; it returns the controller to idle
//   and drops out_ch.valid. The result sits in an output register, so the
//   next input word is taken while a finished result still waits. If the
//   receiver has not taken it when the next conversion ends, the
//   controller holds that conversion until the output register is free.
module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  esc_in_if.sink   in_ch,
  esc_out_if.source out_ch
);

  esc_cmd_t cmd;
  esc_sts_t sts;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  esc_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .epoch_seconds   (in_ch.epoch_seconds),
    .sts             (sts),
    .second          (out_ch.second),
    .minute          (out_ch.minute),
    .hour            (out_ch.hour),
    .day_of_month    (out_ch.day_of_month),
    .month_index     (out_ch.month_index),
    .year_since_1900 (out_ch.year_since_1900)
  );

  // Only one conversion is in flight: after a word is taken, the input
  // side closes until the controller is back to idle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a conversion was running");

  // The year and month loops never step at the same time, nor does the divider with the year loop.
  a_loops_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.year_step && cmd.month_step) && !(cmd.div_step && cmd.year_step))
    else $error("datapath commands overlap");

  // Loading the result register always raises the output valid.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_ch.valid)
    else $error("result loaded but not presented");

  // A presented date always has a month index in range and a nonzero day.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.month_index <= LAST_MONTH) &&
                     (out_ch.day_of_month != MDAY_W'(0)))
    else $error("month or day out of range");

endmodule

// ===== tb/tb_epoch_seconds_to_calendar.sv =====
// Self-checking testbench for epoch_seconds_to_calendar: directed dates, then random traffic.
// Depends on esc_pkg, the esc_in_if/esc_out_if channel interfaces and the converter RTL.
module tb_epoch_seconds_to_calendar;
  import esc_pkg::*;

  // The limit allows roughly 475 words at the slowest conversion, with sender
  // gaps and receiver stalls added, many times over.
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned DRAIN_CYCLES   = 250;
  localparam int unsigned RANDOM_PER_MIX = 112;
  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned EPOCH_MAX      = 32'hFFFF_FFFF;

  // One broken-down date, at the widths of the result channel.
  typedef struct packed {
    logic [SEC_W-1:0]  second;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [MDAY_W-1:0] day_of_month;
    logic [MON_W-1:0]  month_index;
    logic [YEAR_W-1:0] year_since_1900;
  } calendar_t;

  logic clk = 1'b0;
  logic rst_n;

  esc_in_if  in_if ();
  esc_out_if out_if ();

  epoch_seconds_to_calendar u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Dates still owed by the block, oldest first, with the seconds that produced each one.
  calendar_t        pending_dates[$];
  logic [31:0]      pending_epochs[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned words_sent;
  int unsigned dates_checked;
  int unsigned mismatches;
  int unsigned cycle_count;

  // Days in each month of a common year; February gains a day in a leap year.
  int unsigned common_month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  function automatic bit is_leap_year(input int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  function automatic int unsigned year_length(input int unsigned year);
    return is_leap_year(year) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(input int unsigned year, input int unsigned mon);
    return (mon == 1 && is_leap_year(year)) ? 29 : common_month_len[mon];
  endfunction

  // Seconds at 00:00:00 of the given date; mon counts from 0 and day from 1.
  function automatic longint epoch_of_date(input int unsigned year, input int unsigned mon,
                                           input int unsigned day);
    longint days;
    days = 0;
    for (int unsigned y = 1970; y < year; y++) days += year_length(y);
    for (int unsigned m = 0; m < mon; m++) days += month_length(year, m);
    days += day - 1;
    return days * SECS_PER_DAY;
  endfunction

  // Expected calendar fields for one count of seconds since the epoch.
  function automatic calendar_t predict_calendar(input logic [31:0] secs);
    calendar_t   date;
    longint      rest;
    int unsigned days;
    int unsigned year;
    int unsigned mon;
    rest = secs;
    date.second = SEC_W'(rest % 60);
    rest = rest / 60;
    date.minute = MIN_W'(rest % 60);
    rest = rest / 60;
    date.hour = HOUR_W'(rest % 24);
    days = int'(rest / 24);
    // Strip whole years first, then whole months of the year that is left.
    year = 1970;
    while (days >= year_length(year)) begin
      days -= year_length(year);
      year++;
    end
    mon = 0;
    while (mon < 11 && days >= month_length(year, mon)) begin
      days -= month_length(year, mon);
      mon++;
    end
    date.day_of_month    = MDAY_W'(days + 1);
    date.month_index     = MON_W'(mon);
    date.year_since_1900 = YEAR_W'(year - 1900);
    return date;
  endfunction

  // Clamp a date arithmetic result into the 32-bit input range.
  function automatic logic [31:0] clamp_epoch(input longint value);
    if (value < 0) return 32'd0;
    if (value > longint'(EPOCH_MAX)) return EPOCH_MAX;
    return value[31:0];
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want,
                                 input logic [31:0] secs);
    $display("mismatch: %s got %0d, expected %0d, for epoch %0d (cycle %0d)",
             field, got, want, secs, cycle_count);
    mismatches++;
  endtask

  // Send one word on the input channel. The task is entered and left at a falling
  // edge, and it leaves valid high, so that back-to-back words never lower and raise
  // valid in the same time step; the caller lowers it when the stimulus is over.
  task automatic send_epoch(input logic [31:0] secs);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.epoch_seconds <= secs;
    do @(posedge clk); while (!in_if.ready);
    // The word moved at this rising edge, so the date it implies is now owed.
    pending_dates.push_back(predict_calendar(secs));
    pending_epochs.push_back(secs);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_date(input int unsigned year, input int unsigned mon,
                           input int unsigned day, input longint offset);
    send_epoch(clamp_epoch(epoch_of_date(year, mon, day) + offset));
  endtask

  // One random count of seconds. Most picks land near year and month edges, where
  // the year and month searches change their answer; others spread over the range or sit near its ends.
  function automatic logic [31:0] pick_epoch();
    int unsigned kind;
    int unsigned year;
    int unsigned mon;
    longint      offset;
    kind   = $urandom_range(0, 99);
    offset = longint'($urandom_range(0, 4 * SECS_PER_DAY)) - 2 * SECS_PER_DAY;
    if (kind < 30) begin
      return $urandom;
    end else if (kind < 50) begin
      year = $urandom_range(1970, 2106);
      return clamp_epoch(epoch_of_date(year, 0, 1) + offset);
    end else if (kind < 72) begin
      year = $urandom_range(1970, 2105);
      mon  = $urandom_range(0, 11);
      return clamp_epoch(epoch_of_date(year, mon, 1) + offset);
    end else if (kind < 82) begin
      // Leap days, including that of the century year 2000.
      year = 4 * $urandom_range(493, 526);
      return clamp_epoch(epoch_of_date(year, 1, 29) + offset);
    end else if (kind < 92) begin
      // Early 1970 keeps some conversions short, so stalls meet a quick block.
      return $urandom_range(0, 40 * SECS_PER_DAY);
    end else begin
      return EPOCH_MAX - $urandom_range(0, 400 * SECS_PER_DAY);
    end
  endfunction

  // Field boundaries of the time of day, the ends and middle of the input range and alternating bit patterns.
  task automatic test_field_extremes();
    send_epoch(32'd0);
    send_epoch(32'd59);
    send_epoch(32'd60);
    send_epoch(32'd3599);
    send_epoch(32'd3600);
    send_epoch(32'd86399);
    send_epoch(32'd86400);
    send_epoch(32'h7FFF_FFFF);
    send_epoch(32'h8000_0000);
    send_epoch(32'hAAAA_AAAA);
    send_epoch(32'h5555_5555);
    send_epoch(EPOCH_MAX);
    send_epoch(EPOCH_MAX - 1);
  endtask

  // Leap years, the leap century 2000, the common century 2100 and the last day of
  // the year, where the month search runs all the way to December.
  task automatic test_leap_and_century();
    send_date(1972, 1, 29, 0);
    send_date(1972, 2, 1, -1);
    send_date(1972, 11, 31, 86399);
    send_date(1973, 0, 1, -1);
    send_date(2000, 1, 29, 43200);
    send_date(2000, 11, 31, 86399);
    send_date(2001, 0, 1, 0);
    send_date(2100, 1, 28, 86399);
    send_date(2100, 2, 1, 0);
    send_date(2100, 11, 31, 86399);
    send_date(2104, 1, 29, 0);
    send_date(2106, 0, 1, 0);
  endtask

  // Random words under each mix of sender gaps and receiver stalls in turn.
  task automatic test_random_traffic();
    int unsigned idle_mix  [4] = '{0, 58, 0, 13};
    int unsigned stall_mix [4] = '{0, 0, 58, 13};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_mix[p];
      receiver_stall_pct = stall_mix[p];
      for (int unsigned n = 0; n < RANDOM_PER_MIX; n++) send_epoch(pick_epoch());
    end
  endtask

  // The receiver takes or refuses a result word at random, changing at falling edges.
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Every result word taken is compared, field by field, with the oldest date owed.
  always @(posedge clk) begin
    calendar_t   want;
    logic [31:0] secs;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_dates.size() == 0) begin
        $display("mismatch: result word with no date owed (cycle %0d)", cycle_count);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        secs = pending_epochs.pop_front();
        dates_checked++;
        if (out_if.second !== want.second)
          report_mismatch("second", out_if.second, want.second, secs);
        if (out_if.minute !== want.minute)
          report_mismatch("minute", out_if.minute, want.minute, secs);
        if (out_if.hour !== want.hour)
          report_mismatch("hour", out_if.hour, want.hour, secs);
        if (out_if.day_of_month !== want.day_of_month)
          report_mismatch("day_of_month", out_if.day_of_month, want.day_of_month, secs);
        if (out_if.month_index !== want.month_index)
          report_mismatch("month_index", out_if.month_index, want.month_index, secs);
        if (out_if.year_since_1900 !== want.year_since_1900)
          report_mismatch("year_since_1900", out_if.year_since_1900,
                          want.year_since_1900, secs);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d dates owed", cycle_count,
               pending_dates.size());
      $display("FAIL epoch_seconds_to_calendar");
      $finish;
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.epoch_seconds = '0;
    out_if.ready        = 1'b0;
    rst_n               = 1'b0;
    sender_idle_pct     = 0;
    receiver_stall_pct  = 0;
    words_sent          = 0;
    dates_checked       = 0;
    mismatches          = 0;
    cycle_count         = 0;

    // Reset is held low from the start and released at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_field_extremes();
    test_leap_and_century();
    test_random_traffic();
    in_if.valid <= 1'b0;

    // Let the last conversions finish, then watch a while for stray result words.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_dates.size() != 0) begin
      $display("mismatch: %0d dates never returned", pending_dates.size());
      mismatches++;
    end

    $display("Converted %0d words and checked %0d dates, 1970 through 2106,", words_sent,
             dates_checked);
    $display("under four mixes of sender gaps and receiver stalls; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS epoch_seconds_to_calendar");
    end else begin
      $display("FAIL epoch_seconds_to_calendar");
    end
    $finish;
  end

endmodule
